FILE: hdl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define PLA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check a consequent in the cycle after its antecedent.
`define PLA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/pla_pkg.sv
// Shared types and constants of the polyline length accumulator.
`default_nettype none

package pla_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int TOTAL_BITS_DEF = 40;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABS,
    ST_MUL,
    ST_SUM1,
    ST_SUM2,
    ST_ROOT,
    ST_FIN
  } pla_state_t;

  // Load and step controls of a serial arithmetic unit.
  typedef struct packed {
    logic load;
    logic step;
  } pla_unit_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/pla_if.sv
// Point and result stream interfaces.
`default_nettype none

interface pla_point_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic                         start_new;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;

  modport source (output valid, start_new, point_x, point_y, point_z, input ready);
  modport sink (input valid, start_new, point_x, point_y, point_z, output ready);
endinterface

interface pla_result_if #(
  parameter int COORD_BITS = 24,
  parameter int TOTAL_BITS = 40
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS:0]   segment_length;
  logic [TOTAL_BITS-1:0] total_length;
  logic                  saturated;

  modport source (output valid, segment_length, total_length, saturated, input ready);
  modport sink (input valid, segment_length, total_length, saturated, output ready);
endinterface

`default_nettype wire

FILE: hdl/pla_sq_lane.sv
// Bit-serial squarer of one coordinate difference.
`default_nettype none

module pla_sq_lane
  import pla_pkg::*;
#(
  parameter int DW = COORD_BITS_DEF
) (
  input  wire logic            clk,
  input  wire pla_unit_ctrl_t  ctrl,
  input  wire logic [DW:0]     diff,
  output logic [2*DW-1:0]      square
);

  logic [DW-1:0]   mcand;
  logic [2*DW-1:0] prod;
  logic [DW:0]     mag_wide;
  logic [DW:0]     partial;

  // Take the magnitude of the two's complement difference
  assign mag_wide = diff[DW] ? (~diff + {{DW{1'b0}}, 1'b1}) : diff;

  // Add the multiplicand into the upper half when the next multiplier bit is set
  assign partial = {1'b0, prod[2*DW-1:DW]} + (prod[0] ? {1'b0, mcand} : {(DW+1){1'b0}});

  // Load magnitude, then shift the product right one bit per step
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mcand <= mag_wide[DW-1:0];
      prod  <= {{DW{1'b0}}, mag_wide[DW-1:0]};
    end else if (ctrl.step) begin
      prod <= {partial, prod[DW-1:1]};
    end
  end

  assign square = prod;

endmodule

`default_nettype wire

FILE: hdl/pla_isqrt.sv
// Digit-by-digit floor square root, one bit pair per cycle while step is high.
`default_nettype none

module pla_isqrt
  import pla_pkg::*;
#(
  parameter int PAIRS = COORD_BITS_DEF + 1
) (
  input  wire logic             clk,
  input  wire pla_unit_ctrl_t   ctrl,
  input  wire logic [2*PAIRS-1:0] radicand,
  output logic [PAIRS-1:0]      root
);

  localparam int RW = PAIRS + 2;

  logic [2*PAIRS-1:0] rad_sh;
  logic [RW-1:0]      rem;
  logic [RW-1:0]      rem_cat;
  logic [RW-1:0]      trial;
  logic               ge;

  // Bring down the next bit pair and form the trial value
  assign rem_cat = {rem[RW-3:0], rad_sh[2*PAIRS-1:2*PAIRS-2]};
  assign trial   = {root, 2'b01};
  assign ge      = (rem_cat >= trial);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rad_sh <= radicand;
      rem    <= '0;
      root   <= '0;
    end else if (ctrl.step) begin
      rad_sh <= {rad_sh[2*PAIRS-3:0], 2'b00};
      rem    <= ge ? (rem_cat - trial) : rem_cat;
      root   <= {root[PAIRS-2:0], ge};
    end
  end

endmodule

`default_nettype wire

FILE: hdl/polyline_length_accumulator_top.sv
// A first point of a polyline goes straight to the result; a later point passes the
// bit-serial squarers, a registered sum of two squares and the one-bit-pair-per-cycle
// square root. The block takes a new point only once the last result is registered.
// Reset: synchronous, clears the control state and the running total; no sweep.
`default_nettype none

module polyline_length_accumulator_top
  import pla_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int TOTAL_BITS = TOTAL_BITS_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  pla_point_if.sink   points,
  pla_result_if.source results
);

  localparam int P     = COORD_BITS + 1;
  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int ACC_W = ((TOTAL_BITS > P) ? TOTAL_BITS : P) + 1;
  localparam int CNT_W = $clog2(P + 1);

  pla_state_t state, state_next;
  pla_unit_ctrl_t lane_ctrl, root_ctrl;

  logic [CNT_W-1:0]      cnt;
  logic [COORD_BITS-1:0] prev_x, prev_y, prev_z;
  logic                  have_prev;
  logic                  first;
  logic [COORD_BITS:0]   diff_x, diff_y, diff_z;
  logic [SQ_W-1:0]       sq_x, sq_y, sq_z;
  logic [SQ_W+1:0]       sq_sum;
  logic [SQ_W+1:0]       rad;
  logic [P-1:0]          root;
  logic [TOTAL_BITS-1:0] total;
  logic                  ovf;
  logic [ACC_W-1:0]      acc;
  logic                  over;
  logic                  accept;
  logic                  out_free;

  logic                  res_valid;
  logic [P-1:0]          res_seg;
  logic [TOTAL_BITS-1:0] res_total;
  logic                  res_sat;

  assign accept   = points.valid && points.ready;
  assign out_free = !res_valid || results.ready;

  // Sequence the serial units
  always_comb begin
    state_next     = state;
    lane_ctrl      = '0;
    root_ctrl      = '0;
    points.ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        points.ready = 1'b1;
        if (points.valid) begin
          state_next = (points.start_new || !have_prev) ? ST_FIN : ST_ABS;
        end
      end
      ST_ABS: begin
        lane_ctrl.load = 1'b1;
        state_next     = ST_MUL;
      end
      ST_MUL: begin
        lane_ctrl.step = 1'b1;
        if (cnt == '0) begin
          state_next = ST_SUM1;
        end
      end
      ST_SUM1: begin
        state_next = ST_SUM2;
      end
      ST_SUM2: begin
        root_ctrl.load = 1'b1;
        state_next     = ST_ROOT;
      end
      ST_ROOT: begin
        root_ctrl.step = 1'b1;
        if (cnt == '0) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Count the steps of the squarers and of the root
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == ST_ABS) begin
      cnt <= CNT_W'(COORD_BITS - 1);
    end else if (state == ST_SUM2) begin
      cnt <= CNT_W'(P - 1);
    end else if (cnt != '0) begin
      cnt <= cnt - {{(CNT_W-1){1'b0}}, 1'b1};
    end
  end

  // Capture the point, its differences and whether it opens a polyline
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
    end else if (accept) begin
      have_prev <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      first  <= points.start_new || !have_prev;
      diff_x <= {points.point_x[COORD_BITS-1], points.point_x} - {prev_x[COORD_BITS-1], prev_x};
      diff_y <= {points.point_y[COORD_BITS-1], points.point_y} - {prev_y[COORD_BITS-1], prev_y};
      diff_z <= {points.point_z[COORD_BITS-1], points.point_z} - {prev_z[COORD_BITS-1], prev_z};
      prev_x <= points.point_x;
      prev_y <= points.point_y;
      prev_z <= points.point_z;
    end
  end

  pla_sq_lane #(.DW(COORD_BITS)) u_lane_x (
    .clk(clk), .ctrl(lane_ctrl), .diff(diff_x), .square(sq_x)
  );
  pla_sq_lane #(.DW(COORD_BITS)) u_lane_y (
    .clk(clk), .ctrl(lane_ctrl), .diff(diff_y), .square(sq_y)
  );
  pla_sq_lane #(.DW(COORD_BITS)) u_lane_z (
    .clk(clk), .ctrl(lane_ctrl), .diff(diff_z), .square(sq_z)
  );

  // Add the first two squares into a register; the third is added combinationally
  always_ff @(posedge clk) begin
    if (state == ST_SUM1) begin
      sq_sum <= {2'b00, sq_x} + {2'b00, sq_y};
    end
  end

  assign rad = sq_sum + {2'b00, sq_z};

  pla_isqrt #(.PAIRS(P)) u_isqrt (
    .clk(clk), .ctrl(root_ctrl), .radicand(rad), .root(root)
  );

  // Saturating add of the segment to the total
  assign acc  = ACC_W'(total) + ACC_W'(root);
  assign over = |acc[ACC_W-1:TOTAL_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      ovf   <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      if (first) begin
        total <= '0;
        ovf   <= 1'b0;
      end else if (over) begin
        total <= '1;
        ovf   <= 1'b1;
      end else begin
        total <= acc[TOTAL_BITS-1:0];
      end
    end
  end

  // Hold the result beat until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      if (first) begin
        res_seg   <= '0;
        res_total <= '0;
        res_sat   <= 1'b0;
      end else if (over) begin
        res_seg   <= root;
        res_total <= '1;
        res_sat   <= 1'b1;
      end else begin
        res_seg   <= root;
        res_total <= acc[TOTAL_BITS-1:0];
        res_sat   <= ovf;
      end
    end
  end

  assign results.valid          = res_valid;
  assign results.segment_length = res_seg;
  assign results.total_length   = res_total;
  assign results.saturated      = res_sat;

endmodule

`default_nettype wire

FILE: hdl/pla_checker.sv
// Port-level checker of the polyline length accumulator and its bind.
`default_nettype none

`include "assert_macros.svh"

module pla_checker
  import pla_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int TOTAL_BITS = TOTAL_BITS_DEF
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [COORD_BITS:0]   seg,
  input wire logic [TOTAL_BITS-1:0] total,
  input wire logic                  sat
);

  // One point in flight: an accepted beat drops ready
  `PLA_ASSERT_NXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready)

  // A stalled result beat holds
  `PLA_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(seg) && $stable(total) && $stable(sat))

  // A saturated total sits at its maximum
  `PLA_ASSERT_IMP(a_sat_max, clk, rst, out_valid && sat, total == {TOTAL_BITS{1'b1}})

  // An unsaturated total covers the latest segment
  `PLA_ASSERT_IMP(a_total_covers, clk, rst, out_valid && !sat, seg <= total)

endmodule

bind polyline_length_accumulator_top pla_checker #(
  .COORD_BITS(COORD_BITS),
  .TOTAL_BITS(TOTAL_BITS)
) u_pla_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (points.valid),
  .in_ready (points.ready),
  .out_valid(results.valid),
  .out_ready(results.ready),
  .seg      (results.segment_length),
  .total    (results.total_length),
  .sat      (results.saturated)
);

`default_nettype wire

FILE: sim/pla_length_checker.sv
// Checker for the polyline length accumulator: predicts each result and compares the output beats.
module pla_length_checker
  import pla_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int TOTAL_BITS = TOTAL_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  pla_point_if  points,
  pla_result_if results,
  output int    mismatches,
  output int    lengths_due,
  output int    lengths_checked
);

  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
  localparam int SQ_W  = 2 * COORD_BITS + 2;
  localparam int ACC_W = ((TOTAL_BITS > COORD_BITS + 1) ? TOTAL_BITS : COORD_BITS + 1) + 1;

  typedef struct packed {
    logic [COORD_BITS:0]   seg;
    logic [TOTAL_BITS-1:0] total;
    logic                  sat;
  } polyline_step_t;

  // Predicted polyline state
  logic signed [COORD_BITS-1:0] last_x, last_y, last_z;
  logic [TOTAL_BITS-1:0]        run_total;
  logic                         have_last;
  logic                         sat_flag;

  polyline_step_t due_lengths[$];
  int             fail_cnt;
  int             pass_cnt;

  // Magnitude of the difference of two signed coordinates
  function automatic logic [COORD_BITS-1:0] coord_gap(input logic signed [COORD_BITS-1:0] a,
                                                      input logic signed [COORD_BITS-1:0] b);
    logic signed [COORD_BITS:0] d;
    d = (COORD_BITS+1)'(a) - (COORD_BITS+1)'(b);
    if (d[COORD_BITS]) d = -d;
    return d[COORD_BITS-1:0];
  endfunction

  // Floor square root, one bit pair per step from the top
  function automatic logic [COORD_BITS:0] floor_root(input logic [2*COORD_BITS+1:0] v);
    logic [2*COORD_BITS+3:0] rem;
    logic [2*COORD_BITS+3:0] trial;
    logic [COORD_BITS:0]     root;
    rem  = '0;
    root = '0;
    for (int i = COORD_BITS; i >= 0; i--) begin
      rem   = {rem[2*COORD_BITS+1:0], v[2*i +: 2]};
      trial = {{(COORD_BITS+1){1'b0}}, root, 2'b01};
      if (rem >= trial) begin
        rem  = rem - trial;
        root = {root[COORD_BITS-1:0], 1'b1};
      end else begin
        root = {root[COORD_BITS-1:0], 1'b0};
      end
    end
    return root;
  endfunction

  // Advance the predicted polyline by one point and form its result
  task automatic advance_polyline(input logic first, input logic signed [COORD_BITS-1:0] x,
                                  input logic signed [COORD_BITS-1:0] y,
                                  input logic signed [COORD_BITS-1:0] z,
                                  output polyline_step_t r);
    logic [COORD_BITS-1:0]   gx, gy, gz;
    logic [2*COORD_BITS+1:0] sq;
    logic [COORD_BITS:0]     seg;
    logic [ACC_W-1:0]        acc;
    seg = '0;
    if (first || !have_last) begin
      run_total = '0;
      sat_flag  = 1'b0;
      have_last = 1'b1;
    end else begin
      gx  = coord_gap(x, last_x);
      gy  = coord_gap(y, last_y);
      gz  = coord_gap(z, last_z);
      sq  = SQ_W'(gx) * SQ_W'(gx) + SQ_W'(gy) * SQ_W'(gy) + SQ_W'(gz) * SQ_W'(gz);
      seg = floor_root(sq);
      acc = ACC_W'(run_total) + ACC_W'(seg);
      if (acc > ACC_W'(TOTAL_MAX)) begin
        run_total = TOTAL_MAX;
        sat_flag  = 1'b1;
      end else begin
        run_total = acc[TOTAL_BITS-1:0];
      end
    end
    last_x  = x;
    last_y  = y;
    last_z  = z;
    r.seg   = seg;
    r.total = run_total;
    r.sat   = sat_flag;
  endtask

  // Watch both channels: check result beats first, then predict point beats
  always @(posedge clk) begin
    polyline_step_t want;
    polyline_step_t next;
    if (rst) begin
      last_x    = '0;
      last_y    = '0;
      last_z    = '0;
      run_total = '0;
      have_last = 1'b0;
      sat_flag  = 1'b0;
      due_lengths.delete();
      fail_cnt  = 0;
      pass_cnt  = 0;
    end else begin
      if (results.valid && results.ready) begin
        if (due_lengths.size() == 0) begin
          fail_cnt++;
          $display("%0t: result beat with nothing expected, got seg %0d total %0d sat %0b",
                   $time, results.segment_length, results.total_length, results.saturated);
        end else begin
          want = due_lengths.pop_front();
          pass_cnt++;
          if (results.segment_length !== want.seg) begin
            fail_cnt++;
            $display("%0t: segment_length mismatch, expected %0d, got %0d",
                     $time, want.seg, results.segment_length);
          end
          if (results.total_length !== want.total) begin
            fail_cnt++;
            $display("%0t: total_length mismatch, expected %0d, got %0d",
                     $time, want.total, results.total_length);
          end
          if (results.saturated !== want.sat) begin
            fail_cnt++;
            $display("%0t: saturated mismatch, expected %0b, got %0b",
                     $time, want.sat, results.saturated);
          end
        end
      end
      if (points.valid && points.ready) begin
        advance_polyline(points.start_new, points.point_x, points.point_y, points.point_z,
                         next);
        due_lengths.push_back(next);
      end
    end
    mismatches      <= fail_cnt;
    lengths_due     <= due_lengths.size();
    lengths_checked <= pass_cnt;
  end

endmodule

FILE: sim/tb_polyline_length_accumulator_top.sv
// Testbench top: drives points into the accumulator, paces the result side and gives the verdict.
module tb_polyline_length_accumulator_top;
  import pla_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int TB             = TOTAL_BITS_DEF;
  localparam int RANDOM_POINTS  = 1430;
  localparam int STALL_LIMIT    = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AFTER     = 300;
  localparam int DRAIN_CYCLES   = 2 * CB + 12;
  localparam logic signed [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};

  logic clk = 1'b0;
  logic rst;

  always #2 clk = ~clk;

  pla_point_if  #(.COORD_BITS(CB)) points_ch ();
  pla_result_if #(.COORD_BITS(CB), .TOTAL_BITS(TB)) results_ch ();

  polyline_length_accumulator_top #(
    .COORD_BITS(CB),
    .TOTAL_BITS(TB)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .points  (points_ch),
    .results (results_ch)
  );

  int mismatches;
  int lengths_due;
  int lengths_checked;

  pla_length_checker #(
    .COORD_BITS(CB),
    .TOTAL_BITS(TB)
  ) checker_i (
    .clk             (clk),
    .rst             (rst),
    .points          (points_ch),
    .results         (results_ch),
    .mismatches      (mismatches),
    .lengths_due     (lengths_due),
    .lengths_checked (lengths_checked)
  );

  int   out_beats = 0;
  int   sat_beats = 0;
  int   quiet_cycles = 0;
  int   sent = 0;
  int   lines = 0;
  logic steady = 1'b0;
  logic hold_done = 1'b0;
  logic signed [CB-1:0] px = '0, py = '0, pz = '0;

  // Count result beats and stop the run if nothing moves for too long
  always @(posedge clk) begin
    if (!rst) begin
      if (results_ch.valid && results_ch.ready) begin
        out_beats <= out_beats + 1;
        if (results_ch.saturated) sat_beats <= sat_beats + 1;
      end
      if ((points_ch.valid && points_ch.ready) || (results_ch.valid && results_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
        $display("** polyline_length_accumulator_top: FAILED **");
        $finish;
      end
    end
  end

  // Pace the result side: random stalls, one long hold-off so the block backs up
  initial begin
    results_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && !hold_done && out_beats >= HOLD_AFTER) begin
        hold_done = 1'b1;
        results_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      results_ch.ready <= !rst && (steady || $urandom_range(99) >= 31);
    end
  end

  // Offer one point, idling at random first, and hold it until accepted
  task automatic send_point(input logic first, input logic signed [CB-1:0] x,
                            input logic signed [CB-1:0] y, input logic signed [CB-1:0] z);
    while (!steady && $urandom_range(99) < 31) begin
      points_ch.valid <= 1'b0;
      @(posedge clk);
    end
    points_ch.valid     <= 1'b1;
    points_ch.start_new <= first;
    points_ch.point_x   <= x;
    points_ch.point_y   <= y;
    points_ch.point_z   <= z;
    @(posedge clk);
    while (!points_ch.ready) @(posedge clk);
    px = x;
    py = y;
    pz = z;
    sent++;
    if (first) lines++;
  endtask

  initial begin
    int   regime;
    int   run_len;
    int   n_rand;
    logic first;
    logic signed [CB-1:0] nx, ny, nz;

    rst                 <= 1'b1;
    points_ch.valid     <= 1'b0;
    points_ch.start_new <= 1'b0;
    points_ch.point_x   <= '0;
    points_ch.point_y   <= '0;
    points_ch.point_z   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // First point with no previous point, then full-range diagonals
    send_point(1'b0, '0, '0, '0);
    send_point(1'b0, C_MAX, C_MAX, C_MAX);
    send_point(1'b0, C_MIN, C_MIN, C_MIN);
    send_point(1'b0, C_MIN, C_MIN, C_MIN);
    // Full-range step along one axis, a zero step, then a step of one
    send_point(1'b1, C_MIN, '0, '0);
    send_point(1'b0, C_MAX, '0, '0);
    send_point(1'b0, C_MAX, '0, '0);
    send_point(1'b0, C_MAX - CB'(1), '0, '0);
    // Small segments with exact and inexact roots
    send_point(1'b1, '0, '0, '0);
    send_point(1'b0, CB'(3), CB'(4), '0);
    send_point(1'b0, CB'(3), CB'(4), CB'(12));
    send_point(1'b0, CB'(4), CB'(5), CB'(13));
    send_point(1'b0, '0, C_MAX, '0);
    send_point(1'b0, '0, C_MIN, '0);
    send_point(1'b1, '0, '0, C_MIN);
    send_point(1'b0, '0, '0, C_MAX);
    // Alternating bit patterns and a restart in the middle of a run
    send_point(1'b1, 24'h555555, 24'hAAAAAA, 24'h555555);
    send_point(1'b0, 24'hAAAAAA, 24'h555555, 24'hAAAAAA);
    send_point(1'b0, '1, '1, '1);
    send_point(1'b1, C_MAX, C_MIN, C_MAX);
    send_point(1'b0, C_MIN, C_MAX, C_MIN);
    send_point(1'b0, CB'(1), CB'(1), CB'(1));

    // Random polylines in several coordinate regimes
    n_rand = 0;
    while (n_rand < RANDOM_POINTS) begin
      regime  = $urandom_range(3);
      run_len = ($urandom_range(9) == 0) ? $urandom_range(60, 30) : $urandom_range(12, 1);
      for (int k = 0; k < run_len && n_rand < RANDOM_POINTS; k++) begin
        first = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(29) == 0);
        nx = px;
        ny = py;
        nz = pz;
        case (regime)
          0: begin
            nx = CB'($urandom_range(8191) - 4096);
            ny = CB'($urandom_range(8191) - 4096);
            nz = CB'($urandom_range(8191) - 4096);
          end
          1: begin
            nx = px + CB'($urandom_range(524287) - 262144);
            ny = py + CB'($urandom_range(524287) - 262144);
            nz = pz + CB'($urandom_range(524287) - 262144);
          end
          2: begin
            nx = CB'($urandom());
            ny = CB'($urandom());
            nz = CB'($urandom());
          end
          default: begin
            // move along one or two axes, often to a range limit
            if ($urandom_range(3) == 0) begin
              nx = $urandom_range(1) ? C_MAX : C_MIN;
            end else begin
              nx = CB'($urandom());
            end
            case ($urandom_range(2))
              0: ny = nx;
              1: nz = nx;
              default: ;
            endcase
            if ($urandom_range(2) != 0) nx = px;
          end
        endcase
        steady = (n_rand >= 600 && n_rand < 850);
        send_point(first, nx, ny, nz);
        n_rand++;
      end
    end
    steady = 1'b0;
    points_ch.valid <= 1'b0;

    // Drain, then allow for any stray beats
    @(posedge clk);
    while (lengths_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d points in %0d polylines; %0d results checked, %0d with the total saturated",
             sent, lines, lengths_checked, sat_beats);
    if (mismatches == 0 && lengths_due == 0) begin
      $display("** polyline_length_accumulator_top: PASSED **");
    end else begin
      $display("** polyline_length_accumulator_top: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/pla_pkg.sv
hdl/pla_if.sv
hdl/pla_sq_lane.sv
hdl/pla_isqrt.sv
hdl/polyline_length_accumulator_top.sv
hdl/pla_checker.sv
sim/pla_length_checker.sv
sim/tb_polyline_length_accumulator_top.sv
